>>> design/double_ended_queue_top_defines.svh
// Assertion macros of the double-ended queue RTL, used by deq_ring.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/deq_pkg.sv
// Types and constants of the double-ended queue.
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] STATUS_DONE      = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] push_value;
    } deq_in_t;

    typedef struct packed {
        logic [31:0] front_word;
        logic [31:0] back_word;
        logic [4:0]  occupancy;
        logic        is_empty;
        logic [1:0]  status;
    } deq_out_t;

    typedef struct packed {
        logic    valid;
        deq_in_t item;
    } deq_req_t;

    typedef struct packed {
        logic     valid;
        deq_out_t item;
    } deq_rsp_t;

endpackage

`default_nettype wire

>>> design/deq_ring.sv
// Ring store, pointers and command sequencer of the double-ended queue.
`default_nettype none
`include "double_ended_queue_top_defines.svh"

module deq_ring import deq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  deq_req_t req,
    output logic     req_ready,
    output deq_rsp_t rsp,
    input  logic     rsp_ready
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [1:0]           status_reg, status_next;
    logic                 rd_front_reg, rd_front_next;
    deq_in_t              item_reg, item_next;
    logic [WORD_BITS-1:0] front_reg, front_next;
    logic [WORD_BITS-1:0] back_reg, back_next;
    logic [WORD_BITS-1:0] rd_data_reg;

    logic [WORD_BITS-1:0] mem [DEPTH];

    logic                 wr_en;
    logic [PTR_W-1:0]     wr_addr;
    logic                 rd_en;
    logic [PTR_W-1:0]     rd_addr;

    logic [PTR_W-1:0]     head_inc, head_dec, tail_inc, tail_dec;
    logic                 is_empty, is_full, last_one;
    logic [WORD_BITS+31:0] push_ext;
    logic [WORD_BITS-1:0] word_in;
    logic [WORD_BITS+31:0] front_ext, back_ext;
    logic [CNT_W+4:0]     count_ext;

    assign head_inc = (head_reg == LAST_POS) ? '0 : head_reg + PTR_W'(1);
    assign head_dec = (head_reg == '0) ? LAST_POS : head_reg - PTR_W'(1);
    assign tail_inc = (tail_reg == LAST_POS) ? '0 : tail_reg + PTR_W'(1);
    assign tail_dec = (tail_reg == '0) ? LAST_POS : tail_reg - PTR_W'(1);

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign last_one = (count_reg == CNT_W'(1));

    assign push_ext = {{WORD_BITS{1'b0}}, item_reg.push_value};
    assign word_in  = push_ext[WORD_BITS-1:0];

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        status_next   = status_reg;
        rd_front_next = rd_front_reg;
        item_next     = item_reg;
        front_next    = front_reg;
        back_next     = back_reg;
        wr_en         = 1'b0;
        wr_addr       = head_dec;
        rd_en         = 1'b0;
        rd_addr       = head_inc;
        req_ready     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    item_next  = req.item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = STATUS_DONE;
                state_next  = S_DONE;
                case (item_reg.command)
                    CMD_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = STATUS_PUSH_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = head_dec;
                            head_next  = head_dec;
                            front_next = word_in;
                            count_next = count_reg + CNT_W'(1);
                            if (is_empty)
                            begin
                                tail_next = head_dec;
                                back_next = word_in;
                            end
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = STATUS_PUSH_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = is_empty ? head_reg : tail_inc;
                            tail_next  = wr_addr;
                            back_next  = word_in;
                            count_next = count_reg + CNT_W'(1);
                            if (is_empty)
                            begin
                                head_next  = head_reg;
                                front_next = word_in;
                            end
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = STATUS_POP_EMPTY;
                        end
                        else
                        begin
                            head_next  = head_inc;
                            count_next = count_reg - CNT_W'(1);
                            if (!last_one)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = head_inc;
                                rd_front_next = 1'b1;
                                state_next    = S_READ;
                            end
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = STATUS_POP_EMPTY;
                        end
                        else
                        begin
                            tail_next  = tail_dec;
                            count_next = count_reg - CNT_W'(1);
                            if (!last_one)
                            begin
                                rd_en         = 1'b1;
                                rd_addr       = tail_dec;
                                rd_front_next = 1'b0;
                                state_next    = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STATUS_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                if (rd_front_reg)
                begin
                    front_next = rd_data_reg;
                end
                else
                begin
                    back_next = rd_data_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            status_reg   <= STATUS_DONE;
            rd_front_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            status_reg   <= status_next;
            rd_front_reg <= rd_front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        front_reg <= front_next;
        back_reg  <= back_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= word_in;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Words of an empty queue read as zero.
    assign front_ext = {32'b0, is_empty ? {WORD_BITS{1'b0}} : front_reg};
    assign back_ext  = {32'b0, is_empty ? {WORD_BITS{1'b0}} : back_reg};
    assign count_ext = {5'b0, count_reg};

    assign rsp.valid           = (state_reg == S_DONE);
    assign rsp.item.front_word = front_ext[31:0];
    assign rsp.item.back_word  = back_ext[31:0];
    assign rsp.item.occupancy  = count_ext[4:0];
    assign rsp.item.is_empty   = is_empty;
    assign rsp.item.status     = status_reg;

    `DEQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "Count exceeds the store depth.")
    `DEQ_ASSERT_NEXT(a_flagged_keeps_count, (state_reg == S_EXEC) && (status_next != STATUS_DONE), count_reg == $past(count_reg), "A flagged item changed the count.")
    `DEQ_ASSERT_NOW(a_read_only_when_left, rd_en, (state_reg == S_EXEC) && (count_reg > CNT_W'(1)), "Memory read issued outside a pop that leaves words.")
    `DEQ_ASSERT_NOW(a_read_state_follows_read, state_reg == S_READ, $past(rd_en), "Read state entered without a memory read.")
    `DEQ_ASSERT_NOW(a_no_write_and_read, wr_en, !rd_en, "Memory written and read by the same item.")

endmodule

`default_nettype wire

>>> design/double_ended_queue_top.sv
// Double-ended queue of words in a ring memory, one command item at a time.
// A result passes the sequencer's execute and done states and then the output
// register; a pop that leaves words behind adds a read state, since the new end
// word comes from a memory read. The sequencer works one item through the ring
// memory before taking the next, and a held response stalls it.
// Reset empties the queue: pointers and count clear, the memory is not cleared.
`default_nettype none

module double_ended_queue_top import deq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  deq_in_t  req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output deq_out_t rsp
);

    deq_req_t ring_req;
    deq_rsp_t ring_rsp;
    logic     ring_rsp_ready;
    logic     rsp_valid_reg, rsp_valid_next;
    deq_out_t rsp_reg;

    assign ring_req.valid = req_valid;
    assign ring_req.item  = req;

    deq_ring #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (ring_req),
        .req_ready (req_ready),
        .rsp       (ring_rsp),
        .rsp_ready (ring_rsp_ready)
    );

    // The output register takes a new item when empty or being emptied.
    assign ring_rsp_ready = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ring_rsp.valid && ring_rsp_ready)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_rsp.valid && ring_rsp_ready)
        begin
            rsp_reg <= ring_rsp.item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
